FILE: src/prf_pkg.sv
// prf_pkg: shared types and constants of the page replacement unit
// no dependencies; used by the channel interfaces, the top level and the checker
package prf_pkg;

    localparam int FRAMES_DEF     = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PAGE_W     = 16;
    localparam int FIDX_W     = 3;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd1;

    typedef struct packed {
        logic              op;
        logic [PAGE_W-1:0] page;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [FIDX_W-1:0] frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  fault_count;
        logic [CNT_W-1:0]  hit_count;
    } t_rsp;

endpackage

FILE: src/prf_if.sv
// prf_req_if, prf_rsp_if: valid/ready channels of the page replacement unit
// depends on prf_pkg for the payload types
interface prf_req_if;
    logic          valid;
    logic          ready;
    prf_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prf_rsp_if;
    logic          valid;
    logic          ready;
    prf_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/page_replacement_fifo_lru.sv
// page_replacement_fifo_lru: page frame replacement unit, FIFO or LRU victim choice
// depends on prf_pkg and the channel interfaces in prf_if.sv
//
// usage:
//   i_req carries one transaction per item: op (access or clear) and a page number.
//   o_rsp returns one transaction per item: hit, frame index, evicted page and the
//   saturating fault and hit counts since the last clear.
//   the config port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the policy (index 0)
//   and the number of managed frames (index 1); write it only while idle.
// timing:
//   the lookup over all frames, victim choice and rank update happen in the cycle
//   of acceptance; the result is registered and shows in the cycle after.
//   one item per cycle is sustained while o_rsp.ready is high, with a single result register.
// reset and stall:
//   reset empties all frames, zeroes the counters, selects FIFO and the full
//   frame count, capped at 8. while a result waits on o_rsp.ready, i_req.ready stays low.
module page_replacement_fifo_lru #(
    parameter int FRAMES     = prf_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = prf_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = prf_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [prf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    prf_req_if.sink                        i_req,
    prf_rsp_if.source                      o_rsp
);
    import prf_pkg::*;

    localparam int RW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW0 = $clog2(FRAMES + 1);
    localparam int NW  = (NW0 > CFG_DATA_W) ? NW0 : CFG_DATA_W;
    localparam logic [CFG_DATA_W-1:0] FRAMES_RST = CFG_DATA_W'((FRAMES < 8) ? FRAMES : 8);
    localparam logic [RW-1:0] RANK_TOP = RW'(FRAMES - 1);

    logic [PAGE_BITS-1:0]  r_page  [FRAMES];
    logic [PAGE_BITS-1:0]  n_page  [FRAMES];
    logic [FRAMES-1:0]     r_fvalid, n_fvalid;
    logic [RW-1:0]         r_rrank [FRAMES];
    logic [RW-1:0]         n_rrank [FRAMES];
    logic [RW-1:0]         r_lorder[FRAMES];
    logic [RW-1:0]         n_lorder[FRAMES];
    logic [COUNT_BITS-1:0] r_faults, n_faults;
    logic [COUNT_BITS-1:0] r_hits, n_hits;
    logic                  r_policy;
    logic [CFG_DATA_W-1:0] r_frames;
    t_rsp                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                 accept;
    logic [NW-1:0]        n_act;
    logic [PAGE_BITS-1:0] pg;
    logic [FRAMES-1:0]    act, hit_vec, empty_vec, victim_vec;
    logic [RW-1:0]        sel_rank[FRAMES];
    logic [RW-1:0]        hit_slot, empty_slot, victim_slot, slot;
    logic                 found, empty, ev_valid;
    logic [RW-1:0]        old_rr, old_lo;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign pg          = PAGE_BITS'(i_req.data.page);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        if (r_frames == '0) begin
            n_act = NW'(1);
        end else if (NW'(r_frames) > NW'(FRAMES)) begin
            n_act = NW'(FRAMES);
        end else begin
            n_act = NW'(r_frames);
        end
    end

    always_comb begin
        for (int f = 0; f < FRAMES; f++) begin
            act[f]       = NW'(f) < n_act;
            hit_vec[f]   = act[f] && r_fvalid[f] && (r_page[f] == pg);
            empty_vec[f] = act[f] && !r_fvalid[f];
            sel_rank[f]  = (r_policy == POL_LRU) ? r_rrank[f] : r_lorder[f];
        end
        for (int f = 0; f < FRAMES; f++) begin
            victim_vec[f] = act[f];
            for (int g = 0; g < FRAMES; g++) begin
                if (act[g] && (sel_rank[g] < sel_rank[f])) begin
                    victim_vec[f] = 1'b0;
                end
            end
        end
    end

    // lowest set index wins
    always_comb begin
        hit_slot    = '0;
        empty_slot  = '0;
        victim_slot = '0;
        for (int f = FRAMES - 1; f >= 0; f--) begin
            if (hit_vec[f]) begin
                hit_slot = RW'(f);
            end
            if (empty_vec[f]) begin
                empty_slot = RW'(f);
            end
            if (victim_vec[f]) begin
                victim_slot = RW'(f);
            end
        end
    end

    assign found    = |hit_vec;
    assign empty    = |empty_vec;
    assign ev_valid = !found && !empty;
    assign slot     = found ? hit_slot : (empty ? empty_slot : victim_slot);
    assign old_rr   = r_rrank[slot];
    assign old_lo   = r_lorder[slot];

    always_comb begin
        n_page      = r_page;
        n_fvalid    = r_fvalid;
        n_rrank     = r_rrank;
        n_lorder    = r_lorder;
        n_faults    = r_faults;
        n_hits      = r_hits;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (accept) begin
            n_out_valid = 1'b1;
            if (i_req.data.op == OP_CLEAR) begin
                n_fvalid = '0;
                for (int f = 0; f < FRAMES; f++) begin
                    n_rrank[f]  = RW'(f);
                    n_lorder[f] = RW'(f);
                end
                n_faults = '0;
                n_hits   = '0;
                n_out    = '0;
            end else begin
                for (int g = 0; g < FRAMES; g++) begin
                    if (r_rrank[g] > old_rr) begin
                        n_rrank[g] = r_rrank[g] - RW'(1);
                    end
                end
                n_rrank[slot] = RANK_TOP;
                if (found) begin
                    if (r_hits != '1) begin
                        n_hits = r_hits + COUNT_BITS'(1);
                    end
                end else begin
                    for (int g = 0; g < FRAMES; g++) begin
                        if (r_lorder[g] > old_lo) begin
                            n_lorder[g] = r_lorder[g] - RW'(1);
                        end
                    end
                    n_lorder[slot] = RANK_TOP;
                    n_page[slot]   = pg;
                    n_fvalid[slot] = 1'b1;
                    if (r_faults != '1) begin
                        n_faults = r_faults + COUNT_BITS'(1);
                    end
                end
                n_out.hit           = found;
                n_out.frame_index   = FIDX_W'(slot);
                n_out.evicted_valid = ev_valid;
                n_out.evicted_page  = ev_valid ? PAGE_W'(r_page[slot]) : '0;
                n_out.fault_count   = CNT_W'(n_faults);
                n_out.hit_count     = CNT_W'(n_hits);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_fvalid    <= '0;
            r_faults    <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
            r_policy    <= POL_FIFO;
            r_frames    <= FRAMES_RST;
            for (int f = 0; f < FRAMES; f++) begin
                r_rrank[f]  <= RW'(f);
                r_lorder[f] <= RW'(f);
            end
        end else begin
            r_fvalid    <= n_fvalid;
            r_faults    <= n_faults;
            r_hits      <= n_hits;
            r_out_valid <= n_out_valid;
            r_rrank     <= n_rrank;
            r_lorder    <= n_lorder;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POLICY: r_policy <= i_cfg_data[0];
                    CFG_FRAMES: r_frames <= i_cfg_data;
                    default:    r_policy <= r_policy;
                endcase
            end
        end
    end

endmodule

FILE: src/prf_checker.sv
// prf_checker: port-level assertions for page_replacement_fifo_lru, with its bind
// depends on prf_pkg; attached to the top level by the bind below
module prf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_op,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_hit,
    input logic                       out_ev_valid,
    input logic [prf_pkg::CNT_W-1:0]  out_faults,
    input logic [prf_pkg::CNT_W-1:0]  out_hits
);
    import prf_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while a result is stalled");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready && in_op == OP_CLEAR) |=>
            (out_valid && !out_hit && out_faults == '0 && out_hits == '0))
        else $error("clear transaction did not return a zeroed result");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_hit) |-> !out_ev_valid)
        else $error("eviction reported on a hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_req.valid),
    .in_ready     (i_req.ready),
    .in_op        (i_req.data.op),
    .out_valid    (o_rsp.valid),
    .out_ready    (o_rsp.ready),
    .out_hit      (o_rsp.data.hit),
    .out_ev_valid (o_rsp.data.evicted_valid),
    .out_faults   (o_rsp.data.fault_count),
    .out_hits     (o_rsp.data.hit_count)
);

FILE: tb/page_replacement_fifo_lru_test.sv
// page_replacement_fifo_lru_test: self-checking testbench of the page replacement unit
// depends on prf_pkg, the channel interfaces in prf_if.sv and page_replacement_fifo_lru
// drives directed and random page streams with random idling, predicts each result in
// a scoreboard class and checks every returned transaction field by field
module page_replacement_fifo_lru_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prf_pkg::*;

    localparam int NFRAMES     = FRAMES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ALT_RUN     = 10;
    localparam int LONG_HOLD   = 300;
    localparam int RANK_RECENT = 0;
    localparam int RANK_LOAD   = 1;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    class page_fault_checker;
        logic [PAGE_W-1:0]     page_at[NFRAMES];
        bit                    resident[NFRAMES];
        int unsigned           rank[2][NFRAMES];
        logic [CNT_W-1:0]      faults;
        logic [CNT_W-1:0]      hits;
        logic                  policy;
        logic [CFG_DATA_W-1:0] frames_reg;
        t_rsp                  expected_lookups[$];
        int                    errors;

        function new();
            wipe();
            policy     = POL_FIFO;
            frames_reg = CFG_DATA_W'(NFRAMES);
            errors     = 0;
        endfunction

        function void wipe();
            for (int f = 0; f < NFRAMES; f++) begin
                page_at[f]           = '0;
                resident[f]          = 1'b0;
                rank[RANK_RECENT][f] = f;
                rank[RANK_LOAD][f]   = f;
            end
            faults = '0;
            hits   = '0;
        endfunction

        function int active_count();
            if (frames_reg == 0) return 1;
            if (frames_reg > NFRAMES) return NFRAMES;
            return int'(frames_reg);
        endfunction

        function void promote(int which, int f);
            int unsigned old_rank;
            old_rank = rank[which][f];
            for (int g = 0; g < NFRAMES; g++) begin
                if (rank[which][g] > old_rank) rank[which][g]--;
            end
            rank[which][f] = NFRAMES - 1;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_POLICY) begin
                policy = val[0];
            end else if (idx == CFG_FRAMES) begin
                frames_reg = val;
            end
        endfunction

        function void note_access(t_req r);
            t_rsp        want;
            int          n;
            int          slot;
            int          which;
            bit          found;
            bit          empty;
            int unsigned best;
            want  = '0;
            slot  = 0;
            found = 1'b0;
            empty = 1'b0;
            if (r.op == OP_CLEAR) begin
                wipe();
                expected_lookups.push_back(want);
                return;
            end
            n = active_count();
            for (int f = 0; f < n; f++) begin
                if (!found && resident[f] && page_at[f] == r.page) begin
                    found = 1'b1;
                    slot  = f;
                end
            end
            if (found) begin
                promote(RANK_RECENT, slot);
                if (hits != CNT_TOP) hits++;
            end else begin
                for (int f = 0; f < n; f++) begin
                    if (!empty && !resident[f]) begin
                        empty = 1'b1;
                        slot  = f;
                    end
                end
                if (!empty) begin
                    which = (policy == POL_LRU) ? RANK_RECENT : RANK_LOAD;
                    best  = NFRAMES;
                    for (int f = 0; f < n; f++) begin
                        if (rank[which][f] < best) begin
                            best = rank[which][f];
                            slot = f;
                        end
                    end
                    want.evicted_valid = 1'b1;
                    want.evicted_page  = page_at[slot];
                end
                page_at[slot]  = r.page;
                resident[slot] = 1'b1;
                promote(RANK_RECENT, slot);
                promote(RANK_LOAD, slot);
                if (faults != CNT_TOP) faults++;
            end
            want.hit         = found;
            want.frame_index = FIDX_W'(slot);
            want.fault_count = faults;
            want.hit_count   = hits;
            expected_lookups.push_back(want);
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_lookup(t_rsp got);
            t_rsp want;
            if (expected_lookups.size() == 0) begin
                flag_mismatch("result with no access pending");
                return;
            end
            want = expected_lookups.pop_front();
            compare_field("hit", 32'(got.hit), 32'(want.hit));
            compare_field("frame_index", 32'(got.frame_index), 32'(want.frame_index));
            compare_field("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
            compare_field("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
            compare_field("fault_count", 32'(got.fault_count), 32'(want.fault_count));
            compare_field("hit_count", 32'(got.hit_count), 32'(want.hit_count));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    prf_req_if req_ch();
    prf_rsp_if rsp_ch();

    page_fault_checker sb = new();

    int          req_gap_max   = 0;
    int          rsp_stall_max = 0;
    bit          long_hold     = 1'b0;
    int          n_sent        = 0;
    int          n_settings    = 0;
    int unsigned cycle_count   = 0;

    page_replacement_fifo_lru u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [PAGE_W-1:0] page);
        int gap;
        gap = int'($urandom_range(0, req_gap_max));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= t_req'{op: op, page: page};
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_access(req_ch.data);
        n_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_lookups.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // both registers written back to back while the block is idle
    task automatic apply_settings(logic pol, logic [CFG_DATA_W-1:0] nframes);
        logic [CFG_DATA_W-1:0] pol_word;
        drain();
        pol_word   = CFG_DATA_W'($urandom);
        pol_word[0] = pol;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_POLICY;
        i_cfg_data <= pol_word;
        @(posedge i_clk);
        sb.set_register(CFG_POLICY, pol_word);
        i_cfg_idx  <= CFG_FRAMES;
        i_cfg_data <= nframes;
        @(posedge i_clk);
        sb.set_register(CFG_FRAMES, nframes);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall     = long_hold ? LONG_HOLD : int'($urandom_range(0, rsp_stall_max));
            long_hold = 1'b0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            sb.check_lookup(rsp_ch.data);
        end
    end

    initial begin
        logic [PAGE_W-1:0]     pool[12];
        logic [CFG_DATA_W-1:0] frame_choices[8];
        int                    n_act;
        int                    r;
        int                    k;
        frame_choices = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd2, 4'd9};
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fifo over all frames
        send_item(OP_ACCESS, 16'h0000);
        send_item(OP_ACCESS, 16'hFFFF);
        send_item(OP_ACCESS, 16'h0000);
        send_item(OP_CLEAR, 16'hFFFF);
        send_item(OP_ACCESS, 16'h1234);
        send_item(OP_ACCESS, 16'h1234);
        apply_settings(POL_FIFO, 4'd2);
        send_item(OP_ACCESS, 16'h5555);
        send_item(OP_ACCESS, 16'hAAAA);
        send_item(OP_ACCESS, 16'h5555);
        send_item(OP_ACCESS, 16'h0001);
        apply_settings(POL_LRU, 4'd2);
        send_item(OP_ACCESS, 16'hAAAA);
        send_item(OP_ACCESS, 16'h0002);
        send_item(OP_ACCESS, 16'h0001);
        apply_settings(POL_LRU, 4'd0);
        send_item(OP_ACCESS, 16'h0003);
        send_item(OP_ACCESS, 16'h0004);
        apply_settings(POL_FIFO, 4'd15);
        send_item(OP_ACCESS, 16'h8000);
        send_item(OP_ACCESS, 16'h0003);
        send_item(OP_ACCESS, 16'h7FFF);
        send_item(OP_ACCESS, 16'hAAAA);
        apply_settings(POL_LRU, 4'd8);
        send_item(OP_ACCESS, 16'h0004);
        send_item(OP_ACCESS, 16'h5555);

        for (int phase = 0; phase < 8; phase++) begin
            apply_settings(phase[0], frame_choices[phase]);
            req_gap_max   = (phase % 3 == 1) ? 0 : 15;
            rsp_stall_max = (phase % 4 == 2 || phase == 4) ? 0 : 15;
            n_act = sb.active_count();
            foreach (pool[j]) pool[j] = PAGE_W'($urandom);
            for (int i = 0; i < 162; i++) begin
                if (phase == 3 && i == 40) begin
                    req_gap_max = 0;
                    long_hold   = 1'b1;
                end
                if (phase == 6 && i == 80) drain();
                r = int'($urandom_range(0, 99));
                if (r < 3) begin
                    send_item(OP_CLEAR, PAGE_W'($urandom));
                end else if (r < 13) begin
                    send_item(OP_ACCESS, PAGE_W'($urandom));
                end else begin
                    send_item(OP_ACCESS, pool[$urandom_range(0, n_act + 2)]);
                end
            end
        end

        // one frame, alternating pages: every access faults; then one page repeated: a fault, then hits
        apply_settings(POL_FIFO, 4'd1);
        req_gap_max   = 0;
        rsp_stall_max = 0;
        send_item(OP_CLEAR, 16'h0000);
        for (int i = 0; i < ALT_RUN; i++) send_item(OP_ACCESS, i[0] ? 16'hF0F0 : 16'h0F0F);
        for (int i = 0; i < ALT_RUN; i++) send_item(OP_ACCESS, 16'h0F0F);

        req_ch.valid <= 1'b0;
        for (k = 0; k < 2000 && sb.expected_lookups.size() != 0; k++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.expected_lookups.size() != 0) begin
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.expected_lookups.size()));
        end
        $display("%0d transactions over %0d register settings, both policies, frame counts 0..15",
                 n_sent, n_settings);
        $display("clears, a long output stall with the input backed up, and a full drain pause");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
